>>> rtl/danf_pkg.sv
// shared types and constants for the deduplicating node queue
// no dependencies; imported by the top level, controller and datapath
`timescale 1ns / 1ps

package danf_pkg;

  // fixed field widths
  localparam int NODE_W    = 10;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int NUM_W     = 11;
  localparam int CNT_OUT_W = 11;

  // default node capacity and register reset value
  localparam int          MAX_NODES_DEF = 1024;
  localparam logic [10:0] NUM_NODES_RST = 11'd1024;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACTIVATE  = 2'd0,
    OP_POP       = 2'd1,
    OP_RESET_ALL = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic idle;       // waiting for a beat, membership read address follows the input port
    logic exec;       // execute activate, pop or unused op and load result
    logic fill;       // one sweep step over the membership and ring memories
    logic fill_mark;  // sweep sets bits of in-range nodes (reset-all) or clears all
    logic finish;     // close a reset-all and load its result
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_reset_all;  // held operation is reset-all
    logic out_free;      // output register empty or being taken
    logic fill_last;     // sweep is at the last memory entry
  } ctl_stat_t;

endpackage

>>> rtl/dedup_active_node_fifo.sv
// channel   dir  handshake               payload
// in        in   in_valid / in_stall     operation, node
// out       out  out_valid / out_stall   popped_node, status, queued_count
// cfg       in   cfg_valid / cfg_ready   num_nodes
//
// activate, remove-first and the unused op: accept, then execute behind the registered
// read of the membership and ring memories; execute waits while the result is held
// reset-all: accept, execute, then a sweep of one write per membership entry, then close
// after reset a sweep clears every membership entry with in_stall high; cfg is open
// the result register holds a beat until taken; the next beat is accepted meanwhile and
// waits in execute until the result register frees
// top level of the deduplicating node queue; depends on danf_pkg, danf_ctrl, danf_dp
`timescale 1ns / 1ps

module dedup_active_node_fifo #(
  parameter int MAX_NODES = danf_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [danf_pkg::OP_W-1:0]        operation,
  input  logic [danf_pkg::NODE_W-1:0]      node,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [danf_pkg::NODE_W-1:0]      popped_node,
  output logic [danf_pkg::STATUS_W-1:0]    status,
  output logic [danf_pkg::CNT_OUT_W-1:0]   queued_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [danf_pkg::NUM_W-1:0]       num_nodes
);

  import danf_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // config register takes a write at any time
  assign cfg_ready = 1'b1;

  danf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  danf_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .operation    (operation),
    .node         (node),
    .cfg_valid    (cfg_valid),
    .num_nodes    (num_nodes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_node  (popped_node),
    .status       (status),
    .queued_count (queued_count),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

>>> rtl/danf_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module danf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/danf_ctrl.sv
// controller state machine for the deduplicating node queue
// depends on danf_pkg for command and status structs
`timescale 1ns / 1ps

module danf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  danf_pkg::ctl_stat_t  stat,
  output danf_pkg::ctl_cmd_t   cmd
);

  import danf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_FIN
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.fill_last) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          if (stat.is_reset_all) begin
            state <= S_FILL;
          end else if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_FILL:  if (stat.fill_last) state <= S_FIN;
        S_FIN:   if (stat.out_free) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.fill = 1'b1;
      S_IDLE:  cmd.idle = 1'b1;
      S_EXEC:  cmd.exec = !stat.is_reset_all && stat.out_free;
      S_FILL: begin
        cmd.fill      = 1'b1;
        cmd.fill_mark = 1'b1;
      end
      S_FIN:   cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // an accepted beat always moves on to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state == S_EXEC)
    else $error("accepted beat did not reach execute");

  // a sweep never ends without reaching the last entry
  a_fill_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && !stat.fill_last) |=> state == S_FILL)
    else $error("fill sweep left early");

endmodule

>>> rtl/danf_dp.sv
// datapath: membership and ring memories, pointers, count, config and result register
// depends on danf_pkg and danf_ram
`timescale 1ns / 1ps

module danf_dp #(
  parameter int MAX_NODES = danf_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input payload
  input  logic [danf_pkg::OP_W-1:0]        operation,
  input  logic [danf_pkg::NODE_W-1:0]      node,
  // config
  input  logic                             cfg_valid,
  input  logic [danf_pkg::NUM_W-1:0]       num_nodes,
  // result
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [danf_pkg::NODE_W-1:0]      popped_node,
  output logic [danf_pkg::STATUS_W-1:0]    status,
  output logic [danf_pkg::CNT_OUT_W-1:0]   queued_count,
  // control
  input  danf_pkg::ctl_cmd_t               cmd,
  output danf_pkg::ctl_stat_t              stat
);

  import danf_pkg::*;

  localparam int           AW   = $clog2(MAX_NODES);
  localparam int           CW   = $clog2(MAX_NODES + 1);
  localparam logic [AW-1:0] LAST = AW'(MAX_NODES - 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_NODES);

  // ring position after p, wrapping at the capacity
  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  op_t                 op_q;
  logic [NODE_W-1:0]   node_q;
  logic [NUM_W-1:0]    num_q;
  logic [AW-1:0]       head, head_next;
  logic [AW-1:0]       tail, tail_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       idx;

  logic [31:0]         num_ext, limit_ext, node_ext, port_ext, idx_ext, pop_ext, cnt_ext;
  logic [AW-1:0]       node_addr, port_addr, fill_tail;
  logic                node_ok, idx_in;

  logic                iq_we, iq_wdata, iq_rd;
  logic [AW-1:0]       iq_waddr, iq_raddr;
  logic                rg_we;
  logic [AW-1:0]       rg_waddr, rg_wdata, rg_rd;

  logic [STATUS_W-1:0] st_c;
  logic [AW-1:0]       pop_c;

  // capture the beat while idle
  always_ff @(posedge clk) begin
    if (cmd.idle) begin
      op_q   <= op_t'(operation);
      node_q <= node;
    end
  end

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_q <= NUM_NODES_RST;
    end else if (cfg_valid) begin
      num_q <= num_nodes;
    end
  end

  // active limit, clamped to capacity
  assign num_ext   = 32'(num_q);
  assign limit_ext = (num_ext > 32'(MAX_NODES)) ? 32'(MAX_NODES) : num_ext;
  assign node_ext  = 32'(node_q);
  assign port_ext  = 32'(node);
  assign idx_ext   = 32'(idx);
  assign node_addr = node_ext[AW-1:0];
  assign port_addr = port_ext[AW-1:0];
  assign node_ok   = node_ext < limit_ext;
  assign idx_in    = idx_ext < limit_ext;
  assign fill_tail = (limit_ext == 32'(MAX_NODES)) ? '0 : limit_ext[AW-1:0];

  // membership read follows the input port while idle
  assign iq_raddr = cmd.idle ? port_addr : node_addr;

  danf_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_in_queue (
    .clk   (clk),
    .we    (iq_we),
    .waddr (iq_waddr),
    .wdata (iq_wdata),
    .raddr (iq_raddr),
    .rdata (iq_rd)
  );

  danf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_ring (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (head),
    .rdata (rg_rd)
  );

  // operation execute, sweep writes and reset-all close
  always_comb begin
    iq_we      = 1'b0;
    iq_waddr   = node_addr;
    iq_wdata   = 1'b0;
    rg_we      = 1'b0;
    rg_waddr   = tail;
    rg_wdata   = node_addr;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    st_c       = ST_DONE;
    pop_c      = '0;
    if (cmd.fill) begin
      iq_we    = 1'b1;
      iq_waddr = idx;
      iq_wdata = cmd.fill_mark && idx_in;
      rg_we    = cmd.fill_mark && idx_in;
      rg_waddr = idx;
      rg_wdata = idx;
    end else if (cmd.finish) begin
      head_next  = '0;
      tail_next  = fill_tail;
      count_next = limit_ext[CW-1:0];
    end else if (cmd.exec) begin
      unique case (op_q)
        OP_ACTIVATE: begin
          if (!node_ok) begin
            st_c = ST_OUT_RANGE;
          end else if (iq_rd) begin
            st_c = ST_DUP;
          end else if (count < FULL) begin
            iq_we      = 1'b1;
            iq_wdata   = 1'b1;
            rg_we      = 1'b1;
            tail_next  = nxt(tail);
            count_next = count + CW'(1);
          end
        end
        OP_POP: begin
          if (count == '0) begin
            st_c = ST_EMPTY;
          end else begin
            pop_c      = rg_rd;
            iq_we      = 1'b1;
            iq_waddr   = rg_rd;
            iq_wdata   = 1'b0;
            head_next  = nxt(head);
            count_next = count - CW'(1);
          end
        end
        OP_RESET_ALL, OP_NONE: begin
          st_c = ST_DONE;
        end
        default: st_c = ST_DONE;
      endcase
    end
  end

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // sweep index, wraps back to zero after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.fill) begin
      idx <= nxt(idx);
    end
  end

  assign pop_ext = 32'(pop_c);
  assign cnt_ext = 32'(count_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.finish) begin
      popped_node  <= pop_ext[NODE_W-1:0];
      status       <= st_c;
      queued_count <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign stat.is_reset_all = (op_q == OP_RESET_ALL);
  assign stat.out_free     = !out_valid || !out_stall;
  assign stat.fill_last    = (idx == LAST);

  // occupancy never exceeds capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue count above capacity");

  // pop on an empty queue leaves the pointers alone
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_q == OP_POP && count == '0) |=> (count == '0 && $stable(head)))
    else $error("empty pop changed the queue");

  // activate never shrinks the queue
  a_act_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_q == OP_ACTIVATE) |=> count >= $past(count))
    else $error("activate reduced the count");

  // a finished sweep leaves the index at zero
  a_sweep_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill && idx == LAST) |=> idx == '0)
    else $error("sweep index did not wrap");

endmodule

>>> tb/testbench.sv
// self-checking testbench for dedup_active_node_fifo: directed and random queue operations
// expected beats come from an in-bench queue model; depends on danf_pkg and the rtl top
`timescale 1ns / 1ps

module testbench;
  import danf_pkg::*;

  localparam int NODES = MAX_NODES_DEF;

  typedef struct packed {
    logic [NODE_W-1:0]    popped;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] count;
  } queue_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      operation = OP_ACTIVATE;
  logic [NODE_W-1:0]    node = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [NODE_W-1:0]    popped_node;
  logic [STATUS_W-1:0]  status;
  logic [CNT_OUT_W-1:0] queued_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [NUM_W-1:0]     num_nodes = NUM_NODES_RST;

  // queue model state
  bit [NODES-1:0]    member;
  logic [NODE_W-1:0] ring [NODES];
  int                head_pos;
  int                tail_pos;
  int                occupancy;
  int                cfg_nodes;

  queue_result_t expected_results[$];
  int            failures = 0;
  bit            steady = 1'b0;
  int            hold_requests = 0;
  int            hold_seen = 0;
  int            hold_cycles = 0;

  dedup_active_node_fifo u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .node         (node),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_node  (popped_node),
    .status       (status),
    .queued_count (queued_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .num_nodes    (num_nodes)
  );

  always #6 clk = ~clk;

  // append one node at the tail and mark it queued
  function automatic void enqueue_node(int nd);
    ring[tail_pos] = nd[NODE_W-1:0];
    tail_pos       = (tail_pos + 1) % NODES;
    member[nd]     = 1'b1;
    occupancy++;
  endfunction

  // apply one operation to the queue model and return the beat it produces
  function automatic queue_result_t apply_node_op(op_t op, logic [NODE_W-1:0] nd);
    queue_result_t r;
    int            lim;
    r   = '0;
    lim = (cfg_nodes > NODES) ? NODES : cfg_nodes;
    case (op)
      OP_ACTIVATE: begin
        if (nd >= lim) r.status = ST_OUT_RANGE;
        else if (member[nd]) r.status = ST_DUP;
        else if (occupancy < NODES) enqueue_node(nd);
      end
      OP_POP: begin
        if (occupancy == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped         = ring[head_pos];
          member[r.popped] = 1'b0;
          head_pos         = (head_pos + 1) % NODES;
          occupancy--;
        end
      end
      OP_RESET_ALL: begin
        member    = '0;
        head_pos  = 0;
        tail_pos  = 0;
        occupancy = 0;
        for (int i = 0; i < lim; i++) enqueue_node(i);
      end
      default: ;
    endcase
    r.count = occupancy[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_val, int act_val);
    failures++;
    if (failures <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
  endtask

  // send one beat, with random idle cycles ahead of it unless the stream is steady
  task automatic offer_node_op(op_t op, logic [NODE_W-1:0] nd);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    operation <= op;
    node      <= nd;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_node_op(op, nd));
  endtask

  // random beat: mostly in-range activates and pops, a few resets and unused ops
  task automatic offer_random_op();
    int                r;
    int                lim;
    logic [NODE_W-1:0] nd;
    op_t               op;
    r   = $urandom_range(199);
    lim = (cfg_nodes > NODES) ? NODES : cfg_nodes;
    if (r < 110) op = OP_ACTIVATE;
    else if (r < 190) op = OP_POP;
    else if (r < 196) op = OP_NONE;
    else op = OP_RESET_ALL;
    if (lim > 0 && $urandom_range(99) < 85) nd = NODE_W'($urandom_range(lim - 1, 0));
    else nd = NODE_W'($urandom);
    offer_node_op(op, nd);
  endtask

  // hold the sender off until every expected beat has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // register write, only with the block idle
  task automatic write_node_count(int value);
    wait_for_results();
    cfg_valid <= 1'b1;
    num_nodes <= value[NUM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_nodes = value;
  endtask

  task automatic test_directed_cases();
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_NONE, 10'd1023);
    offer_node_op(OP_ACTIVATE, 10'd0);
    offer_node_op(OP_ACTIVATE, 10'd1023);
    offer_node_op(OP_ACTIVATE, 10'd0);
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_POP, 10'd0);
    // small node set, refill by reset-all
    write_node_count(4);
    offer_node_op(OP_ACTIVATE, 10'd4);
    offer_node_op(OP_ACTIVATE, 10'd3);
    offer_node_op(OP_RESET_ALL, 10'd0);
    offer_node_op(OP_ACTIVATE, 10'd3);
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_ACTIVATE, 10'd0);
    // shrink below queued nodes, they still pop
    write_node_count(2);
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_POP, 10'd0);
    offer_node_op(OP_ACTIVATE, 10'd3);
    offer_node_op(OP_POP, 10'd0);
    // zero nodes: nothing in range, reset-all leaves the queue empty
    write_node_count(0);
    offer_node_op(OP_ACTIVATE, 10'd0);
    offer_node_op(OP_RESET_ALL, 10'd0);
    offer_node_op(OP_POP, 10'd0);
    // oversized register acts as full capacity
    write_node_count(2047);
    offer_node_op(OP_ACTIVATE, 10'd1023);
    offer_node_op(OP_RESET_ALL, 10'd0);
    offer_node_op(OP_ACTIVATE, 10'd512);
    offer_node_op(OP_POP, 10'd0);
  endtask

  task automatic test_register_sweep();
    int settings [9];
    settings = '{1, 7, 64, 1024, 2047, 0, 300, 1024, 1};
    settings[8] = $urandom_range(1024, 1);
    foreach (settings[i]) begin
      write_node_count(settings[i]);
      repeat ((settings[i] == 0) ? 40 : 170) offer_random_op();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (150) offer_random_op();
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    // receiver holds off while the sender keeps offering
    steady = 1'b1;
    hold_requests++;
    repeat (40) offer_random_op();
    steady = 1'b0;
    // sender pauses until the pipe is empty
    wait_for_results();
    repeat (40) offer_random_op();
  endtask

  // receiver stall: long hold-off when requested, else random, none while the stream is steady
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen   = hold_requests;
      hold_cycles = 100;
    end
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 33);
    end
  end

  // compare each taken beat with the oldest expectation
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, count", -1, int'(queued_count));
      end else begin
        exp_r = expected_results.pop_front();
        if (popped_node !== exp_r.popped)
          report_mismatch("popped_node", int'(exp_r.popped), int'(popped_node));
        if (status !== exp_r.status)
          report_mismatch("status", int'(exp_r.status), int'(status));
        if (queued_count !== exp_r.count)
          report_mismatch("queued_count", int'(exp_r.count), int'(queued_count));
      end
    end
  end

  // test sequence
  initial begin
    member    = '0;
    head_pos  = 0;
    tail_pos  = 0;
    occupancy = 0;
    cfg_nodes = int'(NUM_NODES_RST);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_sweep();
    test_steady_stream();
    test_output_backpressure();
    wait_for_results();
    repeat (NODES + 8) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
